// ===== sv/bitmap_page_allocator_assert.svh =====
// Assertion macros shared by the bitmap page allocator RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bpa_pkg.sv =====
// Shared constants and controller/datapath interface types of the page allocator.
package bpa_pkg;

    localparam int WORD_W         = 32;
    localparam int LOG_WORD       = 5;
    localparam int ADDR_W         = 32;
    localparam int COUNT_W        = 11;
    localparam int TOTAL_W        = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int PAGES_DEF      = 1024;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'h0010_0000;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic prep;
        logic scan;
        logic mark_rd;
        logic mark_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic alloc_ok;
        logic free_ok;
        logic found;
        logic scan_fail;
        logic mark_last;
    } t_dp_status;

endpackage

// ===== sv/bpa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bpa_dp.sv =====
// Datapath of the page allocator: bitmap RAM, word scanner, run marker and result register.
module bpa_dp
    import bpa_pkg::*;
#(
    parameter int PAGES      = PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_command,
    input  logic [COUNT_W-1:0]   i_page_count,
    input  logic [ADDR_W-1:0]    i_address,
    output logic [ADDR_W-1:0]    o_address_res,
    output logic                 o_failed
);

    localparam int DEPTH = (PAGES + WORD_W - 1) / WORD_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW0   = $clog2(PAGES + 1);
    localparam int XW    = (TW0 > COUNT_W) ? TW0 : COUNT_W;
    localparam int IW    = (XW > AW + LOG_WORD) ? XW : AW + LOG_WORD;
    localparam int RW    = IW + 1;

    // Configuration registers.
    logic [ADDR_W-1:0]  r_base;
    logic [TOTAL_W-1:0] r_total;

    // Item registers.
    logic               r_cmd;
    logic [COUNT_W-1:0] r_count;
    logic [ADDR_W-1:0]  r_off;

    // Scan and mark state.
    logic [AW:0]     r_raddr;
    logic [AW-1:0]   r_pword;
    logic            r_rvalid;
    logic [RW-1:0]   r_run;
    logic [AW-1:0]   r_waddr;
    logic [RW-1:0]   r_lo;
    logic [RW-1:0]   r_hi;
    logic            r_found;
    logic [ADDR_W-1:0] r_out_addr;
    logic            r_out_failed;

    logic [XW-1:0]       eff_total;
    logic [XW-1:0]       count_x;
    logic [RW-1:0]       eff_m1;
    logic [AW-1:0]       last_word;
    logic [LOG_WORD-1:0] last_bit;
    logic [RW-1:0]       free_lo;
    logic [RW-1:0]       free_sum;
    logic [RW-1:0]       free_hi;
    logic                rd_ok;
    logic                scan_rd;

    logic [WORD_W-1:0]   rd_data;
    logic [WORD_W-1:0]   used_w;
    logic [RW-1:0]       run_w [WORD_W];
    logic [WORD_W-1:0]   hit_w;
    logic                lu_found;
    logic [LOG_WORD-1:0] lu_pos;
    logic [LOG_WORD-1:0] hit_pos;
    logic                hit_any;
    logic [RW-1:0]       start_idx;

    logic [RW-1:0]       hi_m1;
    logic [AW-1:0]       lo_word;
    logic [AW-1:0]       hi_word;
    logic [WORD_W-1:0]   lo_mask;
    logic [WORD_W-1:0]   hi_mask;
    logic [WORD_W-1:0]   run_mask;

    logic                ram_we;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;

    // A total beyond the map size acts as the map size.
    always_comb begin
        count_x   = XW'(r_count);
        eff_total = (XW'(r_total) > XW'(PAGES)) ? XW'(PAGES) : XW'(r_total);
        eff_m1    = RW'(eff_total) - RW'(1);
        last_word = AW'(eff_m1 >> LOG_WORD);
        last_bit  = eff_m1[LOG_WORD-1:0];
        free_lo   = RW'(r_off[XW-1:0]);
        free_sum  = free_lo + RW'(count_x);
        free_hi   = (free_sum > RW'(eff_total)) ? RW'(eff_total) : free_sum;
    end

    assign rd_ok   = (r_raddr <= {1'b0, last_word});
    assign scan_rd = i_cmd.scan && rd_ok;

    // Run length ending at each bit of the fetched word, carrying the run from earlier words.
    always_comb begin
        used_w = rd_data;
        if (r_pword == last_word) begin
            for (int j = 0; j < WORD_W; j++) begin
                if (LOG_WORD'(j) > last_bit) begin
                    used_w[j] = 1'b1;
                end
            end
        end
        for (int j = 0; j < WORD_W; j++) begin
            lu_found = 1'b0;
            lu_pos   = '0;
            for (int k = 0; k <= j; k++) begin
                if (used_w[k]) begin
                    lu_found = 1'b1;
                    lu_pos   = LOG_WORD'(k);
                end
            end
            run_w[j] = lu_found ? (RW'(j) - RW'(lu_pos)) : (r_run + RW'(j + 1));
            hit_w[j] = (run_w[j] >= RW'(count_x));
        end
        hit_pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (hit_w[j]) begin
                hit_pos = LOG_WORD'(j);
            end
        end
        hit_any   = |hit_w;
        start_idx = RW'({r_pword, hit_pos}) + RW'(1) - RW'(count_x);
    end

    // Bit mask of the run within the word being rewritten.
    always_comb begin
        hi_m1    = r_hi - RW'(1);
        lo_word  = AW'(r_lo >> LOG_WORD);
        hi_word  = AW'(hi_m1 >> LOG_WORD);
        lo_mask  = (r_waddr == lo_word) ? ({WORD_W{1'b1}} << r_lo[LOG_WORD-1:0])
                                        : {WORD_W{1'b1}};
        hi_mask  = (r_waddr == hi_word)
                   ? ({WORD_W{1'b1}} >> (LOG_WORD'(WORD_W - 1) - hi_m1[LOG_WORD-1:0]))
                   : {WORD_W{1'b1}};
        run_mask = lo_mask & hi_mask;
    end

    always_comb begin
        ram_we    = i_cmd.clr_wr || i_cmd.mark_wr;
        ram_wdata = '0;
        if (i_cmd.mark_wr) begin
            ram_wdata = (r_cmd == CMD_FREE) ? (rd_data & ~run_mask) : (rd_data | run_mask);
        end
        ram_re    = scan_rd || i_cmd.mark_rd;
        ram_raddr = i_cmd.scan ? r_raddr[AW-1:0] : r_waddr;
    end

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_RESET;
            r_total  <= TOTAL_RESET;
            r_waddr  <= '0;
            r_rvalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE:  r_base  <= i_cfg_data;
                    CFG_TOTAL: r_total <= i_cfg_data[TOTAL_W-1:0];
                    default:   r_base  <= r_base;
                endcase
            end
            r_rvalid <= scan_rd;
            if (i_cmd.clr_wr) begin
                r_waddr <= r_waddr + AW'(1);
            end
            if (i_cmd.prep) begin
                r_waddr <= AW'(free_lo >> LOG_WORD);
                r_found <= 1'b0;
            end
            if (i_cmd.scan && r_rvalid && hit_any) begin
                r_waddr <= AW'(start_idx >> LOG_WORD);
                r_found <= 1'b1;
            end
            if (i_cmd.mark_wr && (r_waddr != hi_word)) begin
                r_waddr <= r_waddr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_count <= i_page_count;
            r_off   <= (i_address - r_base) >> PAGE_SHIFT;
        end
        if (i_cmd.prep) begin
            r_lo    <= free_lo;
            r_hi    <= free_hi;
            r_raddr <= '0;
            r_run   <= '0;
        end
        if (scan_rd) begin
            r_raddr <= r_raddr + (AW + 1)'(1);
            r_pword <= r_raddr[AW-1:0];
        end
        if (i_cmd.scan && r_rvalid) begin
            r_run <= run_w[WORD_W-1];
            if (hit_any) begin
                r_lo <= start_idx;
                r_hi <= start_idx + RW'(count_x);
            end
        end
        if (i_cmd.out_load) begin
            if ((r_cmd == CMD_FREE) || !r_found) begin
                r_out_addr <= '0;
            end else begin
                r_out_addr <= r_base + (ADDR_W'(r_lo) << PAGE_SHIFT);
            end
            r_out_failed <= (r_cmd == CMD_ALLOC) && !r_found;
        end
    end

    always_comb begin
        o_status.clr_last  = (r_waddr == AW'(DEPTH - 1));
        o_status.is_free   = (r_cmd == CMD_FREE);
        o_status.alloc_ok  = (count_x != '0) && (count_x <= eff_total);
        o_status.free_ok   = (r_count != '0) && (r_off < ADDR_W'(eff_total));
        o_status.found     = r_rvalid && hit_any;
        o_status.scan_fail = r_rvalid && !hit_any && (r_pword == last_word);
        o_status.mark_last = (r_waddr == hi_word);
    end

    assign o_address_res = r_out_addr;
    assign o_failed      = r_out_failed;

endmodule

// ===== sv/bpa_ctrl.sv =====
// Controller state machine of the page allocator: sequences clearing, scan, marking and result.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_PREP    = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_MARK_RD = 3'd4;
    localparam logic [2:0] S_MARK_WR = 3'd5;
    localparam logic [2:0] S_RESULT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // The result register frees up in the same cycle its item is taken.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_status.is_free) begin
                    n_state = i_status.free_ok ? S_MARK_RD : S_RESULT;
                end else begin
                    n_state = i_status.alloc_ok ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.found) begin
                    n_state = S_MARK_RD;
                end else if (i_status.scan_fail) begin
                    n_state = S_RESULT;
                end
            end
            S_MARK_RD: begin
                o_cmd.mark_rd = 1'b1;
                n_state       = S_MARK_WR;
            end
            S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                if (i_status.mark_last) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_MARK_RD;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/bitmap_page_allocator.sv =====
// Sequence: accept, a setup state, then for an allocate a scan that reads the 32-page map words
// in turn, then a read and a write state per map word rewritten, then the result register is loaded.
// A free skips the scan. Throughput is one item at a time, bounded by the single RAM port pair.
// The result register lets the next item in.
// After reset the map is zeroed by a pass over all ceil(PAGES/32) map words with the
// input stalled; configuration registers return to their reset values at once.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int PAGES      = PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [COUNT_W-1:0]   i_page_count,
    input  logic [ADDR_W-1:0]    i_address,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ADDR_W-1:0]    o_address_res,
    output logic                 o_failed,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

`include "bitmap_page_allocator_assert.svh"

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    bpa_dp #(
        .PAGES      (PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_page_count  (i_page_count),
        .i_address     (i_address),
        .o_address_res (o_address_res),
        .o_failed      (o_failed)
    );

    `BPA_ASSERT_NEXT(a_accept_starts_setup, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, dp_cmd.prep, "accepted item did not start setup")
    `BPA_ASSERT_NOW(a_no_result_overwrite, i_clk, i_rst_n,
        o_out_valid && i_out_stall, !dp_cmd.out_load, "waiting result overwritten")
    `BPA_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n,
        dp_cmd.out_load, o_out_valid, "loaded result not presented")
    `BPA_ASSERT_NOW(a_single_command, i_clk, i_rst_n,
        1'b1, $onehot0(dp_cmd), "more than one datapath command at once")

endmodule
